// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sfp_pkg.sv =====
`default_nettype none

package sfp_pkg;

   localparam int DATA_WIDTH          = 32;
   localparam int DIFF_WIDTH          = DATA_WIDTH + 1;
   localparam int PROD_WIDTH          = 2 * DATA_WIDTH;
   localparam int UNIT_WIDTH          = DATA_WIDTH + 2;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int ITER_STEPS          = DATA_WIDTH;
   localparam int STEP_WIDTH          = $clog2(ITER_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_X,
      ST_SAT_X,
      ST_DIV_Y,
      ST_SAT_Y,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SUM,
      ST_SQRT,
      ST_OUT
   } sfp_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_PREP,
      OP_ZERO,
      OP_DIV,
      OP_SAT_X,
      OP_SAT_Y,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SUM,
      OP_SQRT,
      OP_OUT
   } sfp_op_type;

   typedef struct packed {
      sfp_op_type op;
   } sfp_cmd_type;

   typedef struct packed {
      logic dt_zero;
   } sfp_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sfp_req_if.sv =====
`default_nettype none

interface sfp_req_if import sfp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  sample_time;
   logic signed [DATA_WIDTH-1:0]  pos_x;
   logic signed [DATA_WIDTH-1:0]  pos_y;

   modport source (output valid, sample_time, pos_x, pos_y, input ready);
   modport sink   (input valid, sample_time, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfp_rsp_if.sv =====
`default_nettype none

interface sfp_rsp_if import sfp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  end_time;
   logic signed [DATA_WIDTH-1:0]  vel_x;
   logic signed [DATA_WIDTH-1:0]  vel_y;
   logic        [DATA_WIDTH-1:0]  speed;
   logic                          zero_interval;

   modport source (output valid, end_time, vel_x, vel_y, speed, zero_interval, input ready);
   modport sink   (input valid, end_time, vel_x, vel_y, speed, zero_interval, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfp_ctrl.sv =====
`default_nettype none

module sfp_ctrl import sfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  sfp_stat_type stat,
   output sfp_cmd_type  cmd
);

   sfp_state_type          state_ff, state_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   step_last;
   logic                   can_load;
   logic                   accept;

   assign step_last = (step_ff == STEP_WIDTH'(ITER_STEPS - 1));
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && have_prev_ff) state_in = ST_PREP;
         ST_PREP:  state_in = stat.dt_zero ? ST_OUT : ST_DIV_X;
         ST_DIV_X: if (step_last) state_in = ST_SAT_X;
         ST_SAT_X: state_in = ST_DIV_Y;
         ST_DIV_Y: if (step_last) state_in = ST_SAT_Y;
         ST_SAT_Y: state_in = ST_SQ_X;
         ST_SQ_X:  state_in = ST_SQ_Y;
         ST_SQ_Y:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_SQRT;
         ST_SQRT:  if (step_last) state_in = ST_OUT;
         ST_OUT:   if (can_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         ST_IDLE:  if (accept) cmd.op = OP_ACCEPT;
         ST_PREP:  cmd.op = stat.dt_zero ? OP_ZERO : OP_PREP;
         ST_DIV_X: cmd.op = OP_DIV;
         ST_SAT_X: cmd.op = OP_SAT_X;
         ST_DIV_Y: cmd.op = OP_DIV;
         ST_SAT_Y: cmd.op = OP_SAT_Y;
         ST_SQ_X:  cmd.op = OP_SQ_X;
         ST_SQ_Y:  cmd.op = OP_SQ_Y;
         ST_SUM:   cmd.op = OP_SUM;
         ST_SQRT:  cmd.op = OP_SQRT;
         ST_OUT:   if (can_load) cmd.op = OP_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      if ((state_ff inside {ST_DIV_X, ST_DIV_Y, ST_SQRT}) && !step_last) begin
         step_in = step_ff + STEP_WIDTH'(1);
      end else begin
         step_in = '0;
      end
      have_prev_in = have_prev_ff || accept;
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sfp_datapath.sv =====
`default_nettype none

module sfp_datapath import sfp_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfp_cmd_type                   cmd,
   output sfp_stat_type                  stat,
   input  logic signed [DATA_WIDTH-1:0]  sample_time,
   input  logic signed [DATA_WIDTH-1:0]  pos_x,
   input  logic signed [DATA_WIDTH-1:0]  pos_y,
   output logic signed [DATA_WIDTH-1:0]  end_time,
   output logic signed [DATA_WIDTH-1:0]  vel_x,
   output logic signed [DATA_WIDTH-1:0]  vel_y,
   output logic        [DATA_WIDTH-1:0]  speed,
   output logic                          zero_interval
);

   localparam int VW = (VALUE_WIDTH < DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
   localparam logic [DIFF_WIDTH-1:0] SAT_HI =
      (DIFF_WIDTH'(1) << (VW - 1)) - DIFF_WIDTH'(1);
   localparam logic [DIFF_WIDTH-1:0] SAT_LO_MAG = SAT_HI + DIFF_WIDTH'(1);

   logic signed [DATA_WIDTH-1:0]  prev_time_ff, prev_x_ff, prev_y_ff;
   logic signed [DATA_WIDTH-1:0]  time_ff;
   logic signed [DIFF_WIDTH-1:0]  dt_ff, dx_ff, dy_ff;
   logic        [DATA_WIDTH-1:0]  divisor_ff, mag_y_ff, quo_ff, root_ff;
   logic                          neg_x_ff, neg_y_ff, zero_ff;
   logic        [UNIT_WIDTH-1:0]  rem_ff;
   logic signed [DATA_WIDTH-1:0]  vel_x_ff, vel_y_ff;
   logic        [PROD_WIDTH-1:0]  prod_ff, acc_ff;
   logic signed [DATA_WIDTH-1:0]  out_time_ff, out_vx_ff, out_vy_ff;
   logic        [DATA_WIDTH-1:0]  out_speed_ff;
   logic                          out_zero_ff;

   logic        [UNIT_WIDTH-1:0]  unit_a, unit_b;
   logic        [UNIT_WIDTH:0]    unit_diff;
   logic                          unit_ge;
   logic signed [DATA_WIDTH-1:0]  mul_a;
   logic signed [PROD_WIDTH-1:0]  mul_out;

   function automatic logic [DATA_WIDTH-1:0] mag_of(input logic signed [DIFF_WIDTH-1:0] v);
      logic [DIFF_WIDTH-1:0] m;
      m = v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
      return m[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [DATA_WIDTH-1:0] sat_of(input logic [DATA_WIDTH-1:0] q,
                                                   input logic neg);
      logic [DIFF_WIDTH-1:0] q_ext;
      logic [DIFF_WIDTH-1:0] r;
      q_ext = {1'b0, q};
      if (!neg) begin
         r = (q_ext > SAT_HI) ? SAT_HI : q_ext;
      end else begin
         r = (q_ext > SAT_LO_MAG) ? DIFF_WIDTH'(-SAT_LO_MAG) : DIFF_WIDTH'(-q_ext);
      end
      return r[DATA_WIDTH-1:0];
   endfunction

   assign stat.dt_zero = (dt_ff == '0);

   // shared subtract/compare: restoring division and digit-by-digit root
   always_comb begin
      case (cmd.op)
         OP_SQRT: begin
            unit_a = {rem_ff[DATA_WIDTH-1:0], acc_ff[PROD_WIDTH-1 -: 2]};
            unit_b = {root_ff, 2'b01};
         end
         default: begin
            unit_a = {1'b0, rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
            unit_b = {2'b00, divisor_ff};
         end
      endcase
   end

   assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
   assign unit_ge   = !unit_diff[UNIT_WIDTH];

   assign mul_a   = (cmd.op == OP_SQ_X) ? vel_x_ff : vel_y_ff;
   assign mul_out = mul_a * mul_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else if (cmd.op == OP_ACCEPT) begin
         prev_time_ff <= sample_time;
         prev_x_ff    <= pos_x;
         prev_y_ff    <= pos_y;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            time_ff <= sample_time;
            dt_ff   <= {sample_time[DATA_WIDTH-1], sample_time}
                       - {prev_time_ff[DATA_WIDTH-1], prev_time_ff};
            dx_ff   <= {pos_x[DATA_WIDTH-1], pos_x} - {prev_x_ff[DATA_WIDTH-1], prev_x_ff};
            dy_ff   <= {pos_y[DATA_WIDTH-1], pos_y} - {prev_y_ff[DATA_WIDTH-1], prev_y_ff};
         end
         OP_PREP: begin
            divisor_ff <= mag_of(dt_ff);
            quo_ff     <= mag_of(dx_ff);
            mag_y_ff   <= mag_of(dy_ff);
            neg_x_ff   <= dx_ff[DIFF_WIDTH-1] ^ dt_ff[DIFF_WIDTH-1];
            neg_y_ff   <= dy_ff[DIFF_WIDTH-1] ^ dt_ff[DIFF_WIDTH-1];
            rem_ff     <= '0;
            zero_ff    <= 1'b0;
         end
         OP_ZERO: begin
            vel_x_ff <= '0;
            vel_y_ff <= '0;
            root_ff  <= '0;
            zero_ff  <= 1'b1;
         end
         OP_DIV: begin
            rem_ff <= unit_ge ? unit_diff[UNIT_WIDTH-1:0] : unit_a;
            quo_ff <= {quo_ff[DATA_WIDTH-2:0], unit_ge};
         end
         OP_SAT_X: begin
            vel_x_ff <= sat_of(quo_ff, neg_x_ff);
            quo_ff   <= mag_y_ff;
            rem_ff   <= '0;
         end
         OP_SAT_Y: begin
            vel_y_ff <= sat_of(quo_ff, neg_y_ff);
         end
         OP_SQ_X: begin
            prod_ff <= mul_out;
         end
         OP_SQ_Y: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_out;
         end
         OP_SUM: begin
            acc_ff  <= acc_ff + prod_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQRT: begin
            rem_ff  <= unit_ge ? unit_diff[UNIT_WIDTH-1:0] : unit_a;
            root_ff <= {root_ff[DATA_WIDTH-2:0], unit_ge};
            acc_ff  <= {acc_ff[PROD_WIDTH-3:0], 2'b00};
         end
         OP_OUT: begin
            out_time_ff  <= time_ff;
            out_vx_ff    <= vel_x_ff;
            out_vy_ff    <= vel_y_ff;
            out_speed_ff <= root_ff;
            out_zero_ff  <= zero_ff;
         end
         default: begin
         end
      endcase
   end

   assign end_time      = out_time_ff;
   assign vel_x         = out_vx_ff;
   assign vel_y         = out_vy_ff;
   assign speed         = out_speed_ff;
   assign zero_interval = out_zero_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/speed_from_position_samples_unit.sv =====
// The first sample after reset only loads the history and gives no result. Later
// samples run PREP, two 32-step divisions with saturation, squares, sum and a 32-step
// square root on the shared 34-bit subtractor, then OUT; a zero interval skips to OUT.
// OUT waits for the last result to be taken; a new sample is accepted only in idle.
// Reset (synchronous, active high) clears history, sequencer and result valid.
`default_nettype none
`include "assert_macros.svh"

module speed_from_position_samples_unit import sfp_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sfp_req_if.sink    req,
   sfp_rsp_if.source  rsp
);

   sfp_cmd_type  cmd;
   sfp_stat_type stat;
   logic         rsp_still;
   logic         rsp_silent;

   sfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfp_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .sample_time   (req.sample_time),
      .pos_x         (req.pos_x),
      .pos_y         (req.pos_y),
      .end_time      (rsp.end_time),
      .vel_x         (rsp.vel_x),
      .vel_y         (rsp.vel_y),
      .speed         (rsp.speed),
      .zero_interval (rsp.zero_interval)
   );

   assign rsp_still  = (rsp.vel_x == '0) && (rsp.vel_y == '0);
   assign rsp_silent = rsp_still && (rsp.speed == '0);

   `SFP_ASSERT_NOW(a_zero_clears, rsp.valid && rsp.zero_interval, rsp_silent, "zero not clear")
   `SFP_ASSERT_NOW(a_still_no_speed, rsp.valid && rsp_still, rsp.speed == '0, "speed at rest")
   `SFP_ASSERT_NEXT(a_load_then_idle, cmd.op == OP_OUT, rsp.valid && req.ready, "load not idle")

endmodule

`default_nettype wire
